[design/x86ild_pkg.sv]
// ----------------------------------------------------------------------------
// x86ild_pkg: shared types, codes and decode functions
// Request types, decode phases and the length rules of the
// 32-bit x86 instruction length decoder.
// ----------------------------------------------------------------------------
package x86ild_pkg;

  // byte values with a fixed role
  localparam logic [7:0] BYTE_LOCK      = 8'hF0;
  localparam logic [7:0] BYTE_REPNE     = 8'hF2;
  localparam logic [7:0] BYTE_REP       = 8'hF3;
  localparam logic [7:0] BYTE_OPSIZE    = 8'h66;
  localparam logic [7:0] BYTE_FPU_BASE  = 8'hD8;
  localparam logic [7:0] BYTE_ESCAPE    = 8'h0F;
  localparam logic [7:0] MODRM_NONE     = 8'hFF;

  // input request
  typedef struct packed {
    logic [7:0] code_byte;
    logic       restart;
  } in_t;

  // result request
  typedef struct packed {
    logic [3:0] instr_length;
    logic       overlong;
    logic [7:0] opcode_value;
    logic       has_modrm;
    logic       two_byte_map;
    logic       fpu_escape;
  } out_t;

  // decode phase
  typedef enum logic [2:0] {
    PH_PREFIX    = 3'd0,
    PH_AFTER_FPU = 3'd1,
    PH_OPCODE    = 3'd2,
    PH_MODRM     = 3'd3,
    PH_SKIP      = 3'd4
  } phase_t;

  // lock, rep, fs/gs, size overrides and the four legacy segment prefixes
  function automatic logic is_prefix(input logic [7:0] b);
    return b == BYTE_LOCK || b == BYTE_REPNE || b == BYTE_REP ||
           (b & 8'hFC) == 8'h64 || (b & 8'hE7) == 8'h26;
  endfunction

  function automatic logic is_fpu_escape(input logic [7:0] b);
    return (b & 8'hF8) == BYTE_FPU_BASE;
  endfunction

  function automatic logic one_byte_needs_modrm(input logic [7:0] op);
    return (op & 8'hC4) == 8'h00 ||
           ((op & 8'hF4) == 8'h60 &&
            ((op & 8'h0A) == 8'h02 || (op & 8'h09) == 8'h09)) ||
           (op & 8'hF0) == 8'h80 ||
           ((op & 8'hF8) == 8'hC0 && (op & 8'h0E) != 8'h02) ||
           (op & 8'hFC) == 8'hD0 ||
           (op & 8'hF6) == 8'hF6;
  endfunction

  function automatic logic two_byte_needs_modrm(input logic [7:0] op);
    logic none;
    none = ((op & 8'hF0) == 8'h00 && op[3:0] >= 4'h4 && (op & 8'h0D) != 8'h0D) ||
           (op & 8'hF0) == 8'h30 ||
           op == 8'h77 ||
           (op & 8'hF0) == 8'h80 ||
           ((op & 8'hF0) == 8'hA0 && op[2:0] <= 3'h2) ||
           (op & 8'hF8) == 8'hC8;
    return !none;
  endfunction

  // sib and displacement bytes after the mod r/m byte
  function automatic logic [3:0] modrm_tail(input logic [7:0] m, input logic mv);
    logic [3:0] n;
    n = 4'd0;
    if (mv) begin
      if (m[2:0] == 3'd4 && m[7:6] != 2'b11) n = n + 4'd1;
      if ((m & 8'hC5) == 8'h05) n = n + 4'd4;
      if (m[7:6] == 2'b01) n = n + 4'd1;
      if (m[7:6] == 2'b10) n = n + 4'd4;
    end
    return n;
  endfunction

  function automatic logic [3:0] immediate_size(input logic [7:0] op, input logic op16,
                                                input logic fpu, input logic esc,
                                                input logic [7:0] m, input logic mv);
    logic [3:0] osz;
    logic       reg0;
    logic [3:0] n;
    osz  = op16 ? 4'd2 : 4'd4;
    reg0 = mv && (m & 8'h30) == 8'h00;
    n    = 4'd0;
    if (fpu) begin
      n = 4'd0;
    end else if (!esc) begin
      if ((op & 8'hC7) == 8'h04 || (op & 8'hFE) == 8'h6A || (op & 8'hF0) == 8'h70 ||
          op == 8'h80 || op == 8'h83 || (op & 8'hFD) == 8'hA0 || op == 8'hA8 ||
          (op & 8'hF8) == 8'hB0 || (op & 8'hFE) == 8'hC0 || op == 8'hC6 ||
          op == 8'hCD || (op & 8'hFE) == 8'hD4 || (op & 8'hF8) == 8'hE0 ||
          op == 8'hEB || (op == 8'hF6 && reg0))
        n = 4'd1;
      else if ((op & 8'hF7) == 8'hC2)
        n = 4'd2;
      else if ((op & 8'hFC) == 8'h80 || (op & 8'hC7) == 8'h05 || (op & 8'hF8) == 8'hB8 ||
               (op & 8'hFE) == 8'hE8 || (op & 8'hFE) == 8'h68 || (op & 8'hFC) == 8'hA0 ||
               (op & 8'hEE) == 8'hA8 || op == 8'hC7 || (op == 8'hF7 && reg0))
        n = osz;
    end else begin
      if (op == 8'hBA || op == 8'h0F || (op & 8'hFC) == 8'h70 || (op & 8'hF7) == 8'hA4 ||
          op == 8'hC2 || op == 8'hC4 || op == 8'hC5 || op == 8'hC6)
        n = 4'd1;
      else if ((op & 8'hF0) == 8'h80)
        n = osz;
    end
    return n;
  endfunction

endpackage

[design/x86_instruction_length_decoder.sv]
// ----------------------------------------------------------------------------
// x86_instruction_length_decoder: streaming 32-bit x86 length decoder
// The final byte is held in the input register, then decoded into the result
// register, which raises out_valid; a result held by out_ready low can stall
// it between the two.
// Throughput: one code byte per cycle while out_ready keeps up; a result held
// by out_ready low stalls the input until it is taken.
// Reset: synchronous active-low rst_n empties both registers and returns the
// decoder to the prefix phase with no partial instruction.
// ----------------------------------------------------------------------------
module x86_instruction_length_decoder #(
  parameter int MAX_LENGTH = 15
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  x86ild_pkg::in_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output x86ild_pkg::out_t  out_data
);

  localparam logic [3:0] MaxLen = 4'(MAX_LENGTH);

  // input register
  logic             in_valid_r;
  x86ild_pkg::in_t  in_data_r;

  // decode state
  x86ild_pkg::phase_t phase_r, phase_nxt;
  logic [3:0] byte_count_r, byte_count_nxt;
  logic       operand_16_r, operand_16_nxt;
  logic       fpu_seen_r, fpu_seen_nxt;
  logic       escape_seen_r, escape_seen_nxt;
  logic [7:0] held_opcode_r, held_opcode_nxt;
  logic [7:0] held_modrm_r, held_modrm_nxt;
  logic       modrm_valid_r, modrm_valid_nxt;
  logic [3:0] bytes_to_skip_r, bytes_to_skip_nxt;

  // result register
  logic             out_valid_r;
  x86ild_pkg::out_t out_data_r;

  logic             adv;
  logic             emit;
  x86ild_pkg::out_t result;

  assign adv       = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  // decode of the registered byte against the current state
  always_comb begin
    logic [7:0] b;
    logic       take;
    logic       sched;
    logic       done;
    logic [3:0] n;
    b     = in_data_r.code_byte;
    take  = 1'b0;
    sched = 1'b0;
    done  = 1'b0;
    n     = 4'd0;

    // restart drops the partial instruction before this byte
    if (in_data_r.restart) begin
      phase_nxt         = x86ild_pkg::PH_PREFIX;
      byte_count_nxt    = 4'd0;
      operand_16_nxt    = 1'b0;
      fpu_seen_nxt      = 1'b0;
      escape_seen_nxt   = 1'b0;
      held_opcode_nxt   = 8'h00;
      held_modrm_nxt    = x86ild_pkg::MODRM_NONE;
      modrm_valid_nxt   = 1'b0;
      bytes_to_skip_nxt = 4'd0;
    end else begin
      phase_nxt         = phase_r;
      byte_count_nxt    = byte_count_r;
      operand_16_nxt    = operand_16_r;
      fpu_seen_nxt      = fpu_seen_r;
      escape_seen_nxt   = escape_seen_r;
      held_opcode_nxt   = held_opcode_r;
      held_modrm_nxt    = held_modrm_r;
      modrm_valid_nxt   = modrm_valid_r;
      bytes_to_skip_nxt = bytes_to_skip_r;
    end
    byte_count_nxt = byte_count_nxt + 4'd1;

    // phase step
    case (phase_nxt)
      x86ild_pkg::PH_PREFIX: begin
        if (x86ild_pkg::is_prefix(b)) begin
          if (b == x86ild_pkg::BYTE_OPSIZE) operand_16_nxt = 1'b1;
        end else if (x86ild_pkg::is_fpu_escape(b)) begin
          fpu_seen_nxt = 1'b1;
          phase_nxt    = x86ild_pkg::PH_AFTER_FPU;
        end else if (b == x86ild_pkg::BYTE_ESCAPE) begin
          escape_seen_nxt = 1'b1;
          phase_nxt       = x86ild_pkg::PH_OPCODE;
        end else begin
          take = 1'b1;
        end
      end
      x86ild_pkg::PH_AFTER_FPU: begin
        if (b == x86ild_pkg::BYTE_ESCAPE) begin
          escape_seen_nxt = 1'b1;
          phase_nxt       = x86ild_pkg::PH_OPCODE;
        end else begin
          take = 1'b1;
        end
      end
      x86ild_pkg::PH_OPCODE: begin
        take = 1'b1;
      end
      x86ild_pkg::PH_MODRM: begin
        held_modrm_nxt  = b;
        modrm_valid_nxt = 1'b1;
        sched           = 1'b1;
      end
      default: begin
        if (bytes_to_skip_nxt != 4'd0) bytes_to_skip_nxt = bytes_to_skip_nxt - 4'd1;
        done = (bytes_to_skip_nxt == 4'd0);
      end
    endcase

    // opcode byte: fpu opcode doubles as mod r/m unless mod is register
    if (take) begin
      held_opcode_nxt = b;
      if (fpu_seen_nxt) begin
        if (b[7:6] != 2'b11) begin
          held_modrm_nxt  = b;
          modrm_valid_nxt = 1'b1;
        end
        sched = 1'b1;
      end else if (escape_seen_nxt ? x86ild_pkg::two_byte_needs_modrm(b)
                                   : x86ild_pkg::one_byte_needs_modrm(b)) begin
        phase_nxt = x86ild_pkg::PH_MODRM;
      end else begin
        sched = 1'b1;
      end
    end

    // remaining sib, displacement and immediate bytes
    if (sched) begin
      n = x86ild_pkg::modrm_tail(held_modrm_nxt, modrm_valid_nxt) +
          x86ild_pkg::immediate_size(held_opcode_nxt, operand_16_nxt, fpu_seen_nxt,
                                     escape_seen_nxt, held_modrm_nxt, modrm_valid_nxt);
      if (n == 4'd0) begin
        done = 1'b1;
      end else begin
        bytes_to_skip_nxt = n;
        phase_nxt         = x86ild_pkg::PH_SKIP;
      end
    end

    emit                = done || (byte_count_nxt >= MaxLen);
    result.instr_length = byte_count_nxt;
    result.overlong     = !done;
    result.opcode_value = held_opcode_nxt;
    result.has_modrm    = modrm_valid_nxt;
    result.two_byte_map = escape_seen_nxt;
    result.fpu_escape   = fpu_seen_nxt;

    // every result returns the state to its reset values
    if (emit) begin
      phase_nxt         = x86ild_pkg::PH_PREFIX;
      byte_count_nxt    = 4'd0;
      operand_16_nxt    = 1'b0;
      fpu_seen_nxt      = 1'b0;
      escape_seen_nxt   = 1'b0;
      held_opcode_nxt   = 8'h00;
      held_modrm_nxt    = x86ild_pkg::MODRM_NONE;
      modrm_valid_nxt   = 1'b0;
      bytes_to_skip_nxt = 4'd0;
    end
  end

  // decode state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= x86ild_pkg::PH_PREFIX;
      byte_count_r    <= 4'd0;
      operand_16_r    <= 1'b0;
      fpu_seen_r      <= 1'b0;
      escape_seen_r   <= 1'b0;
      held_opcode_r   <= 8'h00;
      held_modrm_r    <= x86ild_pkg::MODRM_NONE;
      modrm_valid_r   <= 1'b0;
      bytes_to_skip_r <= 4'd0;
    end else if (adv) begin
      phase_r         <= phase_nxt;
      byte_count_r    <= byte_count_nxt;
      operand_16_r    <= operand_16_nxt;
      fpu_seen_r      <= fpu_seen_nxt;
      escape_seen_r   <= escape_seen_nxt;
      held_opcode_r   <= held_opcode_nxt;
      held_modrm_r    <= held_modrm_nxt;
      modrm_valid_r   <= modrm_valid_nxt;
      bytes_to_skip_r <= bytes_to_skip_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (adv && emit) begin
      out_data_r <= result;
    end
  end

endmodule
